// ===== sv/alle_pkg.sv =====
// ----------------------------------------------------------------------------
// alle_pkg
// Shared types and constants for the array linked list engine: sizes, the
// node layout held in the node memory, operation and status codes, and the
// sequencer states.
// ----------------------------------------------------------------------------
package alle_pkg;

	// Storage sizes
	localparam int DEPTH      = 64;
	localparam int ITEM_WIDTH = 32;

	// Derived widths: a link holds a slot index or the null marker (DEPTH)
	localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LINK_W = $clog2(DEPTH + 1);
	localparam int CNT_W  = $clog2(DEPTH + 1);

	// Fixed field widths of the stream words
	localparam int OPCODE_W   = 3;
	localparam int POSITION_W = 7;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 7;

	localparam int IN_FIELDS_W  = OPCODE_W + POSITION_W + VALUE_W;
	localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = STATUS_W + 3 * VALUE_W + COUNT_W + 1;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	// Position compare width, one bit of headroom for count + 1
	localparam int CMP_W = ((CNT_W > POSITION_W) ? CNT_W : POSITION_W) + 1;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(DEPTH);

	// One node of the list as stored in the node memory
	typedef struct packed {
		logic [ITEM_WIDTH-1:0] payload;
		logic [LINK_W-1:0]     next;
		logic [LINK_W-1:0]     prev;
	} node_t;

	localparam int NODE_W = $bits(node_t);

	typedef enum logic [OPCODE_W-1:0] {
		OP_PUSH_BACK  = 3'd0,
		OP_PUSH_FRONT = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_INSERT     = 3'd4,
		OP_ERASE      = 3'd5,
		OP_READ       = 3'd6,
		OP_CLEAR      = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_IGNORED = 2'd1,
		ST_FULL    = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DEC,
		S_WALK,
		S_INS_NEW,
		S_ERS_B,
		S_POPF,
		S_POPB,
		S_FIX,
		S_RESP
	} state_t;

endpackage

// ===== sv/alle_ram.sv =====
// ----------------------------------------------------------------------------
// alle_ram
// Generic single write port, single read port RAM with a registered read.
// ----------------------------------------------------------------------------
module alle_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/array_linked_list_engine_top.sv =====
// ----------------------------------------------------------------------------
// array_linked_list_engine_top
// Doubly linked list engine over a node memory with index links.
// ----------------------------------------------------------------------------
// One command word is taken at a time and answered with one result word.
// All nodes live in a single node memory (payload, next and prev link per
// slot) with a registered read; every link update is a read-modify-write.
// The result word is loaded as the engine returns to idle. Insert and
// erase at either end cost the same as push and pop. Insert, erase and read
// in the middle walk the next links from the head, one memory read per cycle.
// New nodes take slots from a bump counter; slots are only recycled once
// the list is empty, so a list that has seen DEPTH insertions since it was
// last empty reports full. A new command is accepted once the previous
// result has been loaded into the output register, even while that word
// still waits on m_axis_tready.
// ----------------------------------------------------------------------------
module array_linked_list_engine_top (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_axis_tdata: opcode[2:0], position[9:3], item_value[41:10], zero pad
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [alle_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// m_axis_tdata: status[1:0], read_value[33:2], list_count[40:34],
	// front_value[72:41], back_value[104:73], list_empty[105], zero pad
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [alle_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	import alle_pkg::*;

	// Sequencer and list state
	state_t                state_q, state_d, after_q, after_d;
	op_t                   op_q, op_d;
	logic [POSITION_W-1:0] pos_q, pos_d, rem_q, rem_d;
	logic [ITEM_WIDTH-1:0] val_q, val_d;
	logic [LINK_W-1:0]     head_q, head_d, tail_q, tail_d;
	logic [CNT_W-1:0]      count_q, count_d;
	logic [LINK_W-1:0]     used_q, used_d;
	logic [ITEM_WIDTH-1:0] front_q, front_d, back_q, back_d;
	logic [LINK_W-1:0]     cur_q, cur_d, pv_q, pv_d, nx_q, nx_d;
	logic [LINK_W-1:0]     fix_link_q, fix_link_d;
	logic [SLOT_W-1:0]     fix_addr_q, fix_addr_d;
	logic                  fix_next_q, fix_next_d;
	logic                  fix_front_q, fix_front_d, fix_back_q, fix_back_d;
	status_t               status_q, status_d;
	logic [ITEM_WIDTH-1:0] rd_q, rd_d;
	logic                  out_valid_q, out_valid_d;
	logic [OUT_TDATA_W-1:0] out_data_q, out_data_d;

	// Node memory port
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr, ram_raddr;
	node_t             ram_wnode, rnode;
	logic [NODE_W-1:0] ram_rdata;

	alle_ram #(
		.WIDTH (NODE_W),
		.DEPTH (DEPTH)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wnode),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rnode = node_t'(ram_rdata);

	// Input word unpacking
	logic [VALUE_W-1:0] in_value;
	logic [63:0]        in_value_x;
	assign in_value   = s_axis_tdata[OPCODE_W+POSITION_W +: VALUE_W];
	assign in_value_x = 64'(in_value);

	// Position checks against the current count
	logic [CMP_W-1:0] pos_x, cnt_x;
	logic             full, ins_ok, ers_ok, rd_ok;
	assign pos_x  = CMP_W'(pos_q);
	assign cnt_x  = CMP_W'(count_q);
	assign full   = (used_q == LINK_W'(DEPTH));
	assign ins_ok = (pos_x != '0) && (pos_x <= cnt_x + CMP_W'(1));
	assign ers_ok = (pos_x != '0) && (pos_x <= cnt_x);
	assign rd_ok  = (pos_x < cnt_x);

	// Result word fields
	logic [63:0]        front_x, back_x, rd_x, cnt_w;
	logic [VALUE_W-1:0] front_o, back_o;
	logic               empty_o;
	assign empty_o = (count_q == '0);
	assign front_x = 64'(front_q);
	assign back_x  = 64'(back_q);
	assign rd_x    = 64'(rd_q);
	assign cnt_w   = 64'(count_q);
	assign front_o = empty_o ? '0 : front_x[VALUE_W-1:0];
	assign back_o  = empty_o ? '0 : back_x[VALUE_W-1:0];

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// Next state and memory control
	always_comb begin
		state_d     = state_q;
		after_d     = after_q;
		op_d        = op_q;
		pos_d       = pos_q;
		rem_d       = rem_q;
		val_d       = val_q;
		head_d      = head_q;
		tail_d      = tail_q;
		count_d     = count_q;
		used_d      = used_q;
		front_d     = front_q;
		back_d      = back_q;
		cur_d       = cur_q;
		pv_d        = pv_q;
		nx_d        = nx_q;
		fix_link_d  = fix_link_q;
		fix_addr_d  = fix_addr_q;
		fix_next_d  = fix_next_q;
		fix_front_d = fix_front_q;
		fix_back_d  = fix_back_q;
		status_d    = status_q;
		rd_d        = rd_q;
		out_valid_d = out_valid_q;
		out_data_d  = out_data_q;
		ram_we      = 1'b0;
		ram_waddr   = used_q[SLOT_W-1:0];
		ram_wnode   = '{payload: val_q, next: NULL_LINK, prev: NULL_LINK};
		ram_raddr   = head_q[SLOT_W-1:0];

		// Output register drains independently of the sequencer
		if (out_valid_q && m_axis_tready) begin
			out_valid_d = 1'b0;
		end

		case (state_q)
			S_IDLE: begin
				if (s_axis_tvalid) begin
					op_d    = op_t'(s_axis_tdata[OPCODE_W-1:0]);
					pos_d   = s_axis_tdata[OPCODE_W +: POSITION_W];
					val_d   = in_value_x[ITEM_WIDTH-1:0];
					state_d = S_DEC;
				end
			end

			S_DEC: begin
				status_d    = ST_DONE;
				rd_d        = '0;
				fix_front_d = 1'b0;
				fix_back_d  = 1'b0;
				after_d     = S_RESP;
				state_d     = S_RESP;
				case (op_q)
					OP_PUSH_BACK, OP_PUSH_FRONT, OP_INSERT: begin
						if (op_q == OP_INSERT && !ins_ok) begin
							status_d = ST_IGNORED;
						end else if (full) begin
							status_d = ST_FULL;
						end else if (count_q == '0) begin
							// first node of an empty list
							ram_we    = 1'b1;
							head_d    = used_q;
							tail_d    = used_q;
							front_d   = val_q;
							back_d    = val_q;
							count_d   = CNT_W'(1);
							used_d    = used_q + LINK_W'(1);
						end else if (op_q == OP_PUSH_BACK ||
						             (op_q == OP_INSERT && pos_x == cnt_x + CMP_W'(1))) begin
							// new tail, then link old tail forward
							ram_we     = 1'b1;
							ram_wnode  = '{payload: val_q, next: NULL_LINK, prev: tail_q};
							ram_raddr  = tail_q[SLOT_W-1:0];
							fix_addr_d = tail_q[SLOT_W-1:0];
							fix_next_d = 1'b1;
							fix_link_d = used_q;
							tail_d     = used_q;
							back_d     = val_q;
							count_d    = count_q + CNT_W'(1);
							used_d     = used_q + LINK_W'(1);
							state_d    = S_FIX;
						end else if (op_q == OP_PUSH_FRONT || pos_x == CMP_W'(1)) begin
							// new head, then link old head back
							ram_we     = 1'b1;
							ram_wnode  = '{payload: val_q, next: head_q, prev: NULL_LINK};
							ram_raddr  = head_q[SLOT_W-1:0];
							fix_addr_d = head_q[SLOT_W-1:0];
							fix_next_d = 1'b0;
							fix_link_d = used_q;
							head_d     = used_q;
							front_d    = val_q;
							count_d    = count_q + CNT_W'(1);
							used_d     = used_q + LINK_W'(1);
							state_d    = S_FIX;
						end else begin
							cur_d   = head_q;
							rem_d   = pos_q - POSITION_W'(1);
							state_d = S_WALK;
						end
					end
					OP_POP_FRONT, OP_POP_BACK, OP_ERASE: begin
						if (op_q == OP_ERASE ? !ers_ok : (count_q == '0)) begin
							status_d = ST_IGNORED;
						end else if (count_q == CNT_W'(1)) begin
							head_d  = NULL_LINK;
							tail_d  = NULL_LINK;
							count_d = '0;
							used_d  = '0;
						end else if (op_q == OP_POP_FRONT ||
						             (op_q == OP_ERASE && pos_x == CMP_W'(1))) begin
							ram_raddr = head_q[SLOT_W-1:0];
							state_d   = S_POPF;
						end else if (op_q == OP_POP_BACK || pos_x == cnt_x) begin
							ram_raddr = tail_q[SLOT_W-1:0];
							state_d   = S_POPB;
						end else begin
							cur_d   = head_q;
							rem_d   = pos_q - POSITION_W'(1);
							state_d = S_WALK;
						end
					end
					OP_READ: begin
						if (!rd_ok) begin
							status_d = ST_IGNORED;
						end else begin
							cur_d   = head_q;
							rem_d   = pos_q;
							state_d = S_WALK;
						end
					end
					default: begin
						// clear
						head_d  = NULL_LINK;
						tail_d  = NULL_LINK;
						count_d = '0;
						used_d  = '0;
					end
				endcase
			end

			// Follow next links, one read per cycle; rnode holds node cur_q
			S_WALK: begin
				if (rem_q != '0) begin
					ram_raddr = rnode.next[SLOT_W-1:0];
					cur_d     = rnode.next;
					rem_d     = rem_q - POSITION_W'(1);
				end else begin
					case (op_q)
						OP_INSERT: begin
							// point the target back at the new node
							ram_we    = 1'b1;
							ram_waddr = cur_q[SLOT_W-1:0];
							ram_wnode = '{payload: rnode.payload, next: rnode.next,
							              prev: used_q};
							pv_d      = rnode.prev;
							state_d   = S_INS_NEW;
						end
						OP_ERASE: begin
							pv_d        = rnode.prev;
							nx_d        = rnode.next;
							ram_raddr   = rnode.prev[SLOT_W-1:0];
							fix_addr_d  = rnode.prev[SLOT_W-1:0];
							fix_next_d  = 1'b1;
							fix_link_d  = rnode.next;
							count_d     = count_q - CNT_W'(1);
							after_d     = S_ERS_B;
							state_d     = S_FIX;
						end
						default: begin
							rd_d    = rnode.payload;
							state_d = S_RESP;
						end
					endcase
				end
			end

			// Write the inserted node, then link its predecessor forward
			S_INS_NEW: begin
				ram_we     = 1'b1;
				ram_wnode  = '{payload: val_q, next: cur_q, prev: pv_q};
				ram_raddr  = pv_q[SLOT_W-1:0];
				fix_addr_d = pv_q[SLOT_W-1:0];
				fix_next_d = 1'b1;
				fix_link_d = used_q;
				count_d    = count_q + CNT_W'(1);
				used_d     = used_q + LINK_W'(1);
				after_d    = S_RESP;
				state_d    = S_FIX;
			end

			// Erase, second half: successor points back at predecessor
			S_ERS_B: begin
				ram_raddr  = nx_q[SLOT_W-1:0];
				fix_addr_d = nx_q[SLOT_W-1:0];
				fix_next_d = 1'b0;
				fix_link_d = pv_q;
				after_d    = S_RESP;
				state_d    = S_FIX;
			end

			S_POPF: begin
				ram_raddr   = rnode.next[SLOT_W-1:0];
				fix_addr_d  = rnode.next[SLOT_W-1:0];
				fix_next_d  = 1'b0;
				fix_link_d  = NULL_LINK;
				fix_front_d = 1'b1;
				head_d      = rnode.next;
				count_d     = count_q - CNT_W'(1);
				state_d     = S_FIX;
			end

			S_POPB: begin
				ram_raddr  = rnode.prev[SLOT_W-1:0];
				fix_addr_d = rnode.prev[SLOT_W-1:0];
				fix_next_d = 1'b1;
				fix_link_d = NULL_LINK;
				fix_back_d = 1'b1;
				tail_d     = rnode.prev;
				count_d    = count_q - CNT_W'(1);
				state_d    = S_FIX;
			end

			// Read-modify-write of one link; rnode holds node fix_addr_q
			S_FIX: begin
				ram_we    = 1'b1;
				ram_waddr = fix_addr_q;
				ram_wnode = rnode;
				if (fix_next_q) begin
					ram_wnode.next = fix_link_q;
				end else begin
					ram_wnode.prev = fix_link_q;
				end
				if (fix_front_q) begin
					front_d = rnode.payload;
				end
				if (fix_back_q) begin
					back_d = rnode.payload;
				end
				fix_front_d = 1'b0;
				fix_back_d  = 1'b0;
				state_d     = after_q;
			end

			S_RESP: begin
				if (!out_valid_q || m_axis_tready) begin
					out_valid_d = 1'b1;
					out_data_d  = OUT_TDATA_W'({empty_o, back_o, front_o,
					                            cnt_w[COUNT_W-1:0], rd_x[VALUE_W-1:0],
					                            status_q});
					state_d     = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			after_q     <= S_RESP;
			head_q      <= NULL_LINK;
			tail_q      <= NULL_LINK;
			count_q     <= '0;
			used_q      <= '0;
			fix_front_q <= 1'b0;
			fix_back_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			after_q     <= after_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			count_q     <= count_d;
			used_q      <= used_d;
			fix_front_q <= fix_front_d;
			fix_back_q  <= fix_back_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Payload and working registers
	always_ff @(posedge clk) begin
		op_q       <= op_d;
		pos_q      <= pos_d;
		rem_q      <= rem_d;
		val_q      <= val_d;
		front_q    <= front_d;
		back_q     <= back_d;
		cur_q      <= cur_d;
		pv_q       <= pv_d;
		nx_q       <= nx_d;
		fix_link_q <= fix_link_d;
		fix_addr_q <= fix_addr_d;
		fix_next_q <= fix_next_d;
		status_q   <= status_d;
		rd_q       <= rd_d;
		out_data_q <= out_data_d;
	end

endmodule
